[hdl/tgs_pkg.sv]
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared types, constants and fixed-point helpers for the twiddle gain search.
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int NUM_GAINS = 3;
  localparam int GAIN_W    = 24;
  localparam int STEP_W    = GAIN_W - 1;
  localparam int TOL_W     = 24;
  localparam int INIT_W    = 23;
  localparam int COST_W    = 32;
  localparam int IDX_W     = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
  localparam int SUM_W     = STEP_W + $clog2(NUM_GAINS + 1);
  localparam int CMP_W     = (SUM_W > TOL_W) ? SUM_W : TOL_W;
  localparam int CFG_W     = (TOL_W > INIT_W) ? TOL_W : INIT_W;
  localparam int CFG_IDX_W = 1;
  localparam int K_W       = 17;
  localparam int Q_SHIFT   = 16;
  localparam int SCALED_W  = STEP_W + K_W - Q_SHIFT;

  localparam logic [K_W-1:0]    GROW_Q16   = 17'd72089;
  localparam logic [K_W-1:0]    SHRINK_Q16 = 17'd58982;
  localparam logic [TOL_W-1:0]  TOL_RESET  = 24'd819;
  localparam logic [INIT_W-1:0] INIT_RESET = 23'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE = 1'b0,
    REG_INIT_STEP = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PLUS,
    PH_MINUS,
    PH_DONE
  } phase_t;

  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic [STEP_W-1:0]        step_t;

  typedef struct packed {
    gain_t [NUM_GAINS-1:0] gain;
    logic                  done;
    logic [COST_W-1:0]     best;
  } result_t;

  function automatic gain_t sat_gain(input logic signed [GAIN_W:0] v);
    if (v[GAIN_W] != v[GAIN_W-1]) begin
      return v[GAIN_W] ? {1'b1, {(GAIN_W-1){1'b0}}} : {1'b0, {(GAIN_W-1){1'b1}}};
    end
    return v[GAIN_W-1:0];
  endfunction

  function automatic gain_t trial_gain(input gain_t g, input step_t s, input logic minus);
    logic signed [GAIN_W:0] gx;
    logic signed [GAIN_W:0] sx;
    gx = {g[GAIN_W-1], g};
    sx = {2'b00, s};
    return sat_gain(minus ? gx - sx : gx + sx);
  endfunction

  function automatic step_t scale_step(input step_t s, input logic [K_W-1:0] k);
    logic [STEP_W+K_W-1:0] prod;
    logic [SCALED_W-1:0]   scaled;
    prod   = s * k;
    scaled = prod[STEP_W+K_W-1:Q_SHIFT];
    if (scaled[SCALED_W-1:STEP_W] != '0) begin
      return '1;
    end
    return scaled[STEP_W-1:0];
  endfunction

  function automatic step_t init_step(input logic [INIT_W-1:0] v);
    if (INIT_W > STEP_W && (v >> STEP_W) != '0) begin
      return '1;
    end
    return step_t'(v);
  endfunction

endpackage

[hdl/tgs_core.sv]
// ----------------------------------------------------------------------------
// tgs_core
// Search state and combinational update: gains, steps, best cost, index and
// phase advance on each load and give the next result.
// ----------------------------------------------------------------------------
module tgs_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [tgs_pkg::COST_W-1:0]    cost,
  input  logic                          restart,
  input  logic [tgs_pkg::TOL_W-1:0]     tolerance,
  input  logic [tgs_pkg::INIT_W-1:0]    initial_step,
  output tgs_pkg::result_t              next_result
);
  import tgs_pkg::*;

  gain_t             gains      [NUM_GAINS];
  gain_t             gains_next [NUM_GAINS];
  step_t             steps      [NUM_GAINS];
  step_t             steps_next [NUM_GAINS];
  logic [COST_W-1:0] lowest;
  logic [COST_W-1:0] lowest_next;
  logic [IDX_W-1:0]  index;
  logic [IDX_W-1:0]  index_next;
  phase_t            phase;
  phase_t            phase_next;

  logic [IDX_W-1:0]  sel;
  gain_t             cand;
  gain_t             ncand;
  step_t             grown;
  step_t             shrunk;
  logic              better;
  logic              restart_pass;
  logic              trial;
  logic              adv;
  logic              last;
  logic              within_tol;
  logic [SUM_W-1:0]  step_sum;

  always_comb begin
    sel          = ({1'b0, index} < (IDX_W+1)'(NUM_GAINS)) ? index : '0;
    cand         = trial_gain(gains[sel], steps[sel], phase == PH_MINUS);
    grown        = scale_step(steps[sel], GROW_Q16);
    shrunk       = scale_step(steps[sel], SHRINK_Q16);
    better       = cost < lowest;
    restart_pass = restart || phase == PH_IDLE;
    trial        = phase == PH_PLUS || phase == PH_MINUS;
    gains_next   = gains;
    steps_next   = steps;
    lowest_next  = lowest;
    adv          = 1'b0;
    if (restart_pass) begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        gains_next[k] = '0;
        steps_next[k] = init_step(initial_step);
      end
      lowest_next = cost;
    end else if (trial) begin
      if (better) begin
        lowest_next     = cost;
        gains_next[sel] = cand;
        steps_next[sel] = grown;
        adv             = 1'b1;
      end else if (phase == PH_MINUS) begin
        steps_next[sel] = shrunk;
        adv             = 1'b1;
      end
    end
    step_sum = '0;
    for (int k = 0; k < NUM_GAINS; k++) begin
      step_sum = step_sum + SUM_W'(steps_next[k]);
    end
    within_tol = CMP_W'(step_sum) <= CMP_W'(tolerance);
  end

  always_comb begin
    last       = {1'b0, sel} == (IDX_W+1)'(NUM_GAINS - 1);
    phase_next = phase;
    index_next = index;
    if (restart_pass || (adv && last)) begin
      index_next = '0;
      phase_next = within_tol ? PH_DONE : PH_PLUS;
    end else if (adv) begin
      index_next = sel + 1'b1;
      phase_next = PH_PLUS;
    end else if (phase == PH_PLUS) begin
      phase_next = PH_MINUS;
    end
  end

  always_comb begin
    ncand = trial_gain(gains_next[index_next], steps_next[index_next],
                       phase_next == PH_MINUS);
    for (int k = 0; k < NUM_GAINS; k++) begin
      if ((phase_next == PH_PLUS || phase_next == PH_MINUS) &&
          index_next == IDX_W'(k)) begin
        next_result.gain[k] = ncand;
      end else begin
        next_result.gain[k] = gains_next[k];
      end
    end
    next_result.done = phase_next == PH_DONE;
    next_result.best = lowest_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        gains[k] <= '0;
        steps[k] <= init_step(INIT_RESET);
      end
      lowest <= '1;
      index  <= '0;
      phase  <= PH_IDLE;
    end else if (load) begin
      gains  <= gains_next;
      steps  <= steps_next;
      lowest <= lowest_next;
      index  <= index_next;
      phase  <= phase_next;
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    load && !restart && phase == PH_DONE |=> phase == PH_DONE && $stable(lowest))
    else $error("finished search changed without restart");

  a_done_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> index == '0)
    else $error("finished search with nonzero gain index");

endmodule

[hdl/twiddle_gain_search.sv]
// ----------------------------------------------------------------------------
// twiddle_gain_search
// Twiddle coordinate-descent tuner for three Q12.12 controller gains.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request carries the cost measured for the gains last proposed
//   (restart set: cost of all-zero gains, new search). Each request yields one
//   result request with the next candidate kp/kd/ki, or the final gains with
//   done_res set, and the best cost of the current search.
//   Channels: valid/stall on both sides; a request moves when valid is high
//   and stall is low. Configuration (tolerance, initial_step) is written via
//   cfg_write/cfg_index/cfg_data while no request is in flight.
//   Path: the input register holds a taken request until it loads into the
//   result register (one input register, one result register).
//   Throughput: one request per cycle while out_stall is low; the state
//   update between the two registers is combinational.
//   Reset: gains zero, steps 4096, best cost all ones; the first cost is
//   always treated as a restart.
//   When the receiver stalls, the result register holds, the input register
//   fills, and then stall is raised toward the sender.
// ----------------------------------------------------------------------------
module twiddle_gain_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgs_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tgs_pkg::COST_W-1:0]       cost,
  input  logic                             restart,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [tgs_pkg::GAIN_W-1:0] kp,
  output logic signed [tgs_pkg::GAIN_W-1:0] kd,
  output logic signed [tgs_pkg::GAIN_W-1:0] ki,
  output logic                             done_res,
  output logic [tgs_pkg::COST_W-1:0]       best_cost
);
  import tgs_pkg::*;

  logic [TOL_W-1:0]  tolerance;
  logic [INIT_W-1:0] initial_step;
  logic              s1_valid;
  logic [COST_W-1:0] s1_cost;
  logic              s1_restart;
  logic              out_free;
  logic              load;
  logic              accept;
  result_t           next_result;
  result_t           res;

  assign out_free = !out_valid || !out_stall;
  assign load     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance    <= TOL_RESET;
      initial_step <= INIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOLERANCE: tolerance    <= cfg_data[TOL_W-1:0];
        REG_INIT_STEP: initial_step <= cfg_data[INIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cost    <= cost;
      s1_restart <= restart;
    end
  end

  tgs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .cost         (s1_cost),
    .restart      (s1_restart),
    .tolerance    (tolerance),
    .initial_step (initial_step),
    .next_result  (next_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= next_result;
    end
  end

  assign kp        = res.gain[0];
  assign kd        = res.gain[1];
  assign ki        = res.gain[2];
  assign done_res  = res.done;
  assign best_cost = res.best;

  a_load_out: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("stall raised with room in the pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_cost) && $stable(s1_restart))
    else $error("stalled input register lost its request");

endmodule
